// File: src/assert_macros.svh
// Assertion macros included by modulated_delay_reverb.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When the condition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, cons, msg)
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`endif

`endif

// File: src/mdr_pkg.sv
// ---------------------------------------------------------------------------
// mdr_pkg
// Types, constants and helper functions of the modulated delay reverb.
// ---------------------------------------------------------------------------
`default_nettype none

package mdr_pkg;

  // Default geometry of the two sample lines and the comb taps.
  localparam int DELAY_DEPTH_DEF = 131072;
  localparam int COMB_DEPTH_DEF  = 4096;
  localparam int COMB_TAP_A_DEF  = 1425;
  localparam int COMB_TAP_B_DEF  = 1780;
  localparam int COMB_TAP_C_DEF  = 1972;
  localparam int COMB_TAP_D_DEF  = 2097;

  // Fixed-point constants in Q0.16.
  localparam logic [13:0] Q16_POINT2  = 14'd13107;
  localparam logic [14:0] Q16_POINT3  = 15'd19661;
  localparam logic [15:0] Q16_POINT95 = 16'd62259;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 4'd0,
    REG_LFO_STEP      = 4'd1,
    REG_MOD_DEPTH     = 4'd2,
    REG_FEEDBACK_GAIN = 4'd3,
    REG_HIGHCUT_COEFF = 4'd4,
    REG_COMB_GAIN     = 4'd5,
    REG_BALANCE       = 4'd6,
    REG_MIX           = 4'd7
  } reg_index_t;

  // Register reset values.
  localparam logic [16:0] DELAY_LENGTH_RST  = 17'd24000;
  localparam logic [15:0] LFO_STEP_RST      = 16'd100;
  localparam logic [15:0] MOD_DEPTH_RST     = 16'd0;
  localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd0;
  localparam logic [15:0] HIGHCUT_COEFF_RST = 16'd32768;
  localparam logic [15:0] COMB_GAIN_RST     = 16'd19661;
  localparam logic [15:0] BALANCE_RST       = 16'd0;
  localparam logic [15:0] MIX_RST           = 16'd32768;

  // Sequencer states, one-hot.
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_SINE = 16'h0002,
    S_MOD  = 16'h0004,
    S_MOD2 = 16'h0008,
    S_TAP  = 16'h0010,
    S_ADDR = 16'h0020,
    S_DRD  = 16'h0040,
    S_LP   = 16'h0080,
    S_LP2  = 16'h0100,
    S_FB   = 16'h0200,
    S_WR   = 16'h0400,
    S_CW   = 16'h0800,
    S_REV  = 16'h1000,
    S_MR   = 16'h2000,
    S_OM   = 16'h4000,
    S_FIN  = 16'h8000
  } state_t;

  // Quarter-wave sine in Q1.15, pi/32 steps; entries past the end hold the peak.
  function automatic logic [15:0] quarter_sine(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12540;
      5'd5:    v = 16'd15446;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20787;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25330;
      5'd10:   v = 16'd27245;
      5'd11:   v = 16'd28898;
      5'd12:   v = 16'd30273;
      5'd13:   v = 16'd31356;
      5'd14:   v = 16'd32137;
      5'd15:   v = 16'd32609;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/mdr_in_if.sv
// ---------------------------------------------------------------------------
// mdr_in_if
// Input sample channel: one stereo pair per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_sample;
  logic signed [23:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// File: src/mdr_out_if.sv
// ---------------------------------------------------------------------------
// mdr_out_if
// Output sample channel: one stereo pair per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// File: src/mdr_cfg_if.sv
// ---------------------------------------------------------------------------
// mdr_cfg_if
// Register write channel: index and data per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [mdr_pkg::CFG_IDX_W-1:0]        index;
  logic [mdr_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/modulated_delay_reverb.sv
// Each input beat walks the sequencer from S_SINE to S_FIN, which loads the output pair.
// The sequencer walks the delay and comb memories through their single read ports
// and chains the multiplies; a new input pair is taken only in S_IDLE.
// A waiting output does not block the next input; only the final step waits on it.
// Reset clears control state, configuration registers and filter state; the sample memories are not swept,
// fill counts make never-written entries read as zero, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// modulated_delay_reverb
// LFO-modulated delay with low-pass feedback feeding a comb and allpass reverb.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modulated_delay_reverb #(
  parameter int DELAY_DEPTH = mdr_pkg::DELAY_DEPTH_DEF,
  parameter int COMB_DEPTH  = mdr_pkg::COMB_DEPTH_DEF,
  parameter int COMB_TAP_A  = mdr_pkg::COMB_TAP_A_DEF,
  parameter int COMB_TAP_B  = mdr_pkg::COMB_TAP_B_DEF,
  parameter int COMB_TAP_C  = mdr_pkg::COMB_TAP_C_DEF,
  parameter int COMB_TAP_D  = mdr_pkg::COMB_TAP_D_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mdr_in_if.sink     dry,
  mdr_out_if.source  wet,
  mdr_cfg_if.sink    cfg
);

  localparam int DAW  = $clog2(DELAY_DEPTH);
  localparam int DFW  = $clog2(DELAY_DEPTH + 1);
  localparam int CAW  = $clog2(COMB_DEPTH);
  localparam int CFW  = $clog2(COMB_DEPTH + 1);
  localparam int TA_M = COMB_TAP_A % COMB_DEPTH;
  localparam int TB_M = COMB_TAP_B % COMB_DEPTH;
  localparam int TC_M = COMB_TAP_C % COMB_DEPTH;
  localparam int TD_M = COMB_TAP_D % COMB_DEPTH;

  localparam logic [15:0] Q16_POINT95_W = mdr_pkg::Q16_POINT95;

  // Configuration registers.
  logic        [16:0] delay_length;
  logic        [15:0] lfo_step, mod_depth, feedback_gain, highcut_coeff, comb_gain, mix;
  logic signed [15:0] balance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= mdr_pkg::DELAY_LENGTH_RST;
      lfo_step      <= mdr_pkg::LFO_STEP_RST;
      mod_depth     <= mdr_pkg::MOD_DEPTH_RST;
      feedback_gain <= mdr_pkg::FEEDBACK_GAIN_RST;
      highcut_coeff <= mdr_pkg::HIGHCUT_COEFF_RST;
      comb_gain     <= mdr_pkg::COMB_GAIN_RST;
      balance       <= mdr_pkg::BALANCE_RST;
      mix           <= mdr_pkg::MIX_RST;
    end else if (cfg.valid) begin
      unique case (mdr_pkg::reg_index_t'(cfg.index))
        mdr_pkg::REG_DELAY_LENGTH:  delay_length  <= cfg.data;
        mdr_pkg::REG_LFO_STEP:      lfo_step      <= cfg.data[15:0];
        mdr_pkg::REG_MOD_DEPTH:     mod_depth     <= cfg.data[15:0];
        mdr_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg.data[15:0];
        mdr_pkg::REG_HIGHCUT_COEFF: highcut_coeff <= cfg.data[15:0];
        mdr_pkg::REG_COMB_GAIN:     comb_gain     <= cfg.data[15:0];
        mdr_pkg::REG_BALANCE:       balance       <= cfg.data[15:0];
        mdr_pkg::REG_MIX:           mix           <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state.
  mdr_pkg::state_t state;
  logic [23:0]     phase;
  logic [DAW-1:0]  dwi;
  logic [DFW-1:0]  dfill;
  logic [CAW-1:0]  cwi;
  logic [CFW-1:0]  cfill;
  logic            out_valid;

  // Datapath registers.
  logic signed [23:0] dry_l, dry_r, d_l, lp, c0, c1, c2, c3;
  logic signed [23:0] ap_st [3];
  logic signed [16:0] sin_r;
  logic        [31:0] gfb;
  logic signed [32:0] m_r;
  logic signed [46:0] p_r;
  logic signed [63:0] q_r;
  logic signed [41:0] lpm, ola, ora;
  logic signed [39:0] bpm;
  logic signed [40:0] dmul, cp;
  logic signed [57:0] mdp;
  logic signed [56:0] fbp;
  logic signed [26:0] rev_in;
  logic signed [27:0] rev_r;
  logic signed [43:0] rp;
  logic signed [60:0] mr;
  logic signed [46:0] wm;
  logic signed [23:0] out_l, out_r;
  logic               dok, cok;

  // Memory ports.
  logic [DAW-1:0]     d_raddr;
  logic [23:0]        d_rdata;
  logic               d_we;
  logic signed [23:0] d_wdata;
  logic [CAW-1:0]     c_raddr;
  logic [23:0]        c_rdata;
  logic               c_we;
  logic signed [23:0] c_wdata;

  mdr_ram #(.WIDTH(24), .DEPTH(DELAY_DEPTH)) u_delay_ram (
    .clk(clk), .we(d_we), .waddr(dwi), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  mdr_ram #(.WIDTH(24), .DEPTH(COMB_DEPTH)) u_comb_ram (
    .clk(clk), .we(c_we), .waddr(cwi), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );

  // Sine lookup with linear interpolation between quarter-wave entries.
  logic [22:0]        sp;
  logic [4:0]         sidx;
  logic [15:0]        s_base, s_nxt, s_val;
  logic [33:0]        s_prod;
  logic signed [16:0] s_signed;

  always_comb begin
    sp = {1'b0, phase[21:0]};
    if (phase[22]) begin
      sp = 23'h400000 - {1'b0, phase[21:0]};
    end
    sidx   = sp[22:18];
    s_base = mdr_pkg::quarter_sine(sidx);
    s_nxt  = mdr_pkg::quarter_sine(sidx + 5'd1);
    s_prod = {18'd0, s_nxt - s_base} * {16'd0, sp[17:0]};
    s_val  = (sidx >= 5'd16) ? s_base : s_base + s_prod[33:18];
    s_signed = phase[23] ? -$signed({1'b0, s_val}) : $signed({1'b0, s_val});
  end

  // Modulated tap, clamped, turned into a read address behind the write index.
  logic signed [19:0]  tap_raw, tap_c;
  logic signed [DAW+1:0] d_diff;

  always_comb begin
    tap_raw = $signed({3'b000, delay_length}) + 20'($signed(q_r[63:47]));
    tap_c   = tap_raw;
    if (tap_raw < 20'sd1) begin
      tap_c = 20'sd1;
    end else if (tap_raw > 20'(DELAY_DEPTH - 1)) begin
      tap_c = 20'(DELAY_DEPTH - 1);
    end
    d_diff = $signed({2'b00, dwi}) - $signed(tap_c[DAW+1:0]);
    if (d_diff < 0) begin
      d_diff = d_diff + (DAW+2)'(DELAY_DEPTH);
    end
    d_raddr = d_diff[DAW-1:0];
  end

  // Comb tap address for the read issued in this state.
  logic [CAW:0] c_tap;
  logic [CAW:0] c_diff;

  always_comb begin
    priority case (1'b1)
      state == mdr_pkg::S_LP:  c_tap = (CAW+1)'(TB_M);
      state == mdr_pkg::S_LP2: c_tap = (CAW+1)'(TC_M);
      state == mdr_pkg::S_FB:  c_tap = (CAW+1)'(TD_M);
      default:                 c_tap = (CAW+1)'(TA_M);
    endcase
    c_diff = {1'b0, cwi} + (CAW+1)'(COMB_DEPTH) - c_tap;
    if (c_diff >= (CAW+1)'(COMB_DEPTH)) begin
      c_diff = c_diff - (CAW+1)'(COMB_DEPTH);
    end
    c_raddr = c_diff[CAW-1:0];
  end

  // Line values read through the fill counts: unwritten entries read as zero.
  logic signed [23:0] d_val, c_val;
  assign d_val = dok ? $signed(d_rdata) : 24'sd0;
  assign c_val = cok ? $signed(c_rdata) : 24'sd0;

  // Balance terms.
  logic [15:0] bal_pos, bal_abs;
  assign bal_pos = balance[15] ? 16'd0 : balance;
  assign bal_abs = balance[15] ? 16'(-balance) : balance;

  // Allpass chain over the mean of the four comb taps.
  logic signed [25:0] c_sum;
  logic signed [27:0] ap_r, ap_v;
  logic signed [23:0] ap_next [3];

  always_comb begin
    c_sum = 26'(c0) + 26'(c1) + 26'(c2) + 26'(c3);
    ap_r  = 28'(c_sum >>> 2);
    ap_v  = ap_r;
    for (int i = 0; i < 3; i++) begin
      ap_v       = ap_r + 28'(ap_st[i] >>> 1);
      ap_next[i] = mdr_pkg::sat24(64'(ap_r - (ap_v >>> 1)));
      ap_r       = ap_v;
    end
  end

  // Write data of both lines and the wet sum.
  logic signed [29:0] wet_sum;
  logic signed [42:0] o_l_sum, o_r_sum;
  logic        [16:0] mix_c;

  assign d_wdata = mdr_pkg::sat24(64'(dry_l) + 64'(fbp >>> 32));
  assign c_wdata = mdr_pkg::sat24(64'(rev_in) + 64'(cp >>> 16));
  assign d_we    = (state == mdr_pkg::S_WR);
  assign c_we    = (state == mdr_pkg::S_CW);
  assign wet_sum = 30'(mdp >>> 31) + 30'(mr >>> 32);
  assign mix_c   = 17'd65536 - {1'b0, mix};
  assign o_l_sum = 43'(ola) + 43'(wm);
  assign o_r_sum = 43'(ora) + 43'(wm);

  logic in_fire, out_load;
  assign dry.ready = (state == mdr_pkg::S_IDLE);
  assign in_fire   = dry.valid && dry.ready;
  assign out_load  = (state == mdr_pkg::S_FIN) && (!out_valid || wet.ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mdr_pkg::S_IDLE;
      phase     <= '0;
      dwi       <= '0;
      dfill     <= '0;
      cwi       <= '0;
      cfill     <= '0;
      lp        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ap_st[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (wet.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mdr_pkg::S_IDLE: begin
          if (in_fire) begin
            phase <= phase + {8'd0, lfo_step};
            state <= mdr_pkg::S_SINE;
          end
        end
        mdr_pkg::S_SINE: state <= mdr_pkg::S_MOD;
        mdr_pkg::S_MOD:  state <= mdr_pkg::S_MOD2;
        mdr_pkg::S_MOD2: state <= mdr_pkg::S_TAP;
        mdr_pkg::S_TAP:  state <= mdr_pkg::S_ADDR;
        mdr_pkg::S_ADDR: state <= mdr_pkg::S_DRD;
        mdr_pkg::S_DRD:  state <= mdr_pkg::S_LP;
        mdr_pkg::S_LP:   state <= mdr_pkg::S_LP2;
        mdr_pkg::S_LP2: begin
          lp    <= mdr_pkg::sat24(64'(lp) + 64'(lpm >>> 16));
          state <= mdr_pkg::S_FB;
        end
        mdr_pkg::S_FB:   state <= mdr_pkg::S_WR;
        mdr_pkg::S_WR: begin
          dwi <= (dwi == DAW'(DELAY_DEPTH - 1)) ? '0 : dwi + 1'b1;
          if (dfill != DFW'(DELAY_DEPTH)) begin
            dfill <= dfill + 1'b1;
          end
          state <= mdr_pkg::S_CW;
        end
        mdr_pkg::S_CW: begin
          cwi <= (cwi == CAW'(COMB_DEPTH - 1)) ? '0 : cwi + 1'b1;
          if (cfill != CFW'(COMB_DEPTH)) begin
            cfill <= cfill + 1'b1;
          end
          for (int i = 0; i < 3; i++) begin
            ap_st[i] <= ap_next[i];
          end
          state <= mdr_pkg::S_REV;
        end
        mdr_pkg::S_REV:  state <= mdr_pkg::S_MR;
        mdr_pkg::S_MR:   state <= mdr_pkg::S_OM;
        mdr_pkg::S_OM:   state <= mdr_pkg::S_FIN;
        mdr_pkg::S_FIN: begin
          if (out_load) begin
            state <= mdr_pkg::S_IDLE;
          end
        end
        default: state <= mdr_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath registers, with the multiplies spread over the sequencer states.
  always_ff @(posedge clk) begin
    dok <= ({1'b0, d_raddr} < (DAW+1)'(dfill));
    cok <= ({1'b0, c_raddr} < (CAW+1)'(cfill));
    if (in_fire) begin
      dry_l <= dry.left_sample;
      dry_r <= dry.right_sample;
    end
    unique case (state)
      mdr_pkg::S_SINE: begin
        sin_r <= s_signed;
        gfb   <= feedback_gain * Q16_POINT95_W;
      end
      mdr_pkg::S_MOD:  m_r <= sin_r * $signed({1'b0, mod_depth});
      mdr_pkg::S_MOD2: p_r <= m_r * $signed({1'b0, mdr_pkg::Q16_POINT2});
      mdr_pkg::S_TAP:  q_r <= p_r * $signed({1'b0, delay_length});
      mdr_pkg::S_DRD:  d_l <= d_val;
      mdr_pkg::S_LP: begin
        c0   <= c_val;
        lpm  <= (25'(d_l) - 25'(lp)) * $signed({1'b0, highcut_coeff});
        bpm  <= d_l * $signed({1'b0, bal_pos});
        dmul <= d_l * $signed(17'd32768 - {1'b0, bal_abs});
      end
      mdr_pkg::S_LP2: begin
        c1     <= c_val;
        rev_in <= 27'(dry_l) + 27'(bpm >>> 15);
        mdp    <= dmul * $signed({1'b0, mix});
      end
      mdr_pkg::S_FB: begin
        c2  <= c_val;
        fbp <= lp * $signed({1'b0, gfb});
      end
      mdr_pkg::S_WR: begin
        c3 <= c_val;
        cp <= c_val * $signed({1'b0, comb_gain});
      end
      mdr_pkg::S_CW:  rev_r <= ap_r;
      mdr_pkg::S_REV: rp    <= rev_r * $signed({1'b0, mdr_pkg::Q16_POINT3});
      mdr_pkg::S_MR:  mr    <= rp * $signed({1'b0, mix});
      mdr_pkg::S_OM: begin
        wm  <= wet_sum * $signed({1'b0, mix});
        ola <= dry_l * $signed({1'b0, mix_c});
        ora <= dry_r * $signed({1'b0, mix_c});
      end
      default: ;
    endcase
    if (out_load) begin
      out_l <= mdr_pkg::sat24(64'(o_l_sum >>> 16));
      out_r <= mdr_pkg::sat24(64'(o_r_sum >>> 16));
    end
  end

  assign wet.valid     = out_valid;
  assign wet.left_out  = out_l;
  assign wet.right_out = out_r;

  // Checks on the sequencer and the line bookkeeping.
  `ASSERT_NEXT(a_start, clk, rst, in_fire, state == mdr_pkg::S_SINE, "input beat did not start an item")
  `ASSERT_ALWAYS(a_dwi, clk, rst, {1'b0, dwi} < (DAW+1)'(DELAY_DEPTH), "delay write index out of range")
  `ASSERT_ALWAYS(a_cfill, clk, rst, cfill <= CFW'(COMB_DEPTH), "comb fill count past depth")

endmodule

`default_nettype wire

// File: src/mdr_ram.sv
// ---------------------------------------------------------------------------
// mdr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mdr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
